FILE: sv/cld_pkg.sv
// Shared types, character codes and the header prefix table for the deframer.
package cld_pkg;

    localparam int LEN_WIDTH_DEF = 32;
    localparam int BYTE_W        = 8;
    localparam int PREFIX_LEN    = 15;
    localparam int POS_W         = 4;
    localparam int CNT_W         = 2;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

    localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;

    localparam logic KIND_BODY = 1'b0;
    localparam logic KIND_SKIP = 1'b1;

    typedef enum logic [3:0] {
        PH_PREFIX = 4'b0001,
        PH_BLANK  = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_IGNORE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } result_t;

    function automatic logic [BYTE_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/cld_parser.sv
// Header line parser and body counter: per-byte state update and result decode.
module cld_parser #(
    parameter int LEN_WIDTH = cld_pkg::LEN_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [cld_pkg::BYTE_W-1:0]  in_byte,
    output logic                        res_valid,
    output cld_pkg::result_t            res
);
    import cld_pkg::*;

    localparam int ACC_W = LEN_WIDTH + 4;

    logic                 in_body_reg,  in_body_next;
    phase_t               phase_reg,    phase_next;
    logic [POS_W-1:0]     pos_reg,      pos_next;
    logic [CNT_W-1:0]     cnt_reg,      cnt_next;
    logic                 first_cr_reg, first_cr_next;
    logic [LEN_WIDTH-1:0] value_reg,    value_next;
    logic                 seen_reg,     seen_next;
    logic [LEN_WIDTH-1:0] remain_reg,   remain_next;

    logic [BYTE_W-1:0]    lc;
    logic                 is_digit;
    logic                 is_blank;
    logic [LEN_WIDTH-1:0] acc_base;
    logic [ACC_W-1:0]     acc_ext;
    logic [LEN_WIDTH-1:0] acc_sat;
    logic                 parse_now;
    logic                 line_ends;
    logic                 body_last;

    assign lc       = (in_byte >= CH_UP_A && in_byte <= CH_UP_Z) ? in_byte + CASE_OFS : in_byte;
    assign is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);
    assign is_blank = (in_byte == CH_SP) || (in_byte == CH_TAB);
    assign acc_base = (phase_reg == PH_PREFIX) ? '0 : value_reg;
    assign acc_ext  = (ACC_W'(acc_base) << 3) + (ACC_W'(acc_base) << 1)
                    + ACC_W'(in_byte[3:0]);
    assign acc_sat  = (|acc_ext[ACC_W-1:LEN_WIDTH]) ? '1 : acc_ext[LEN_WIDTH-1:0];
    assign line_ends = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && first_cr_reg);
    assign body_last = (remain_reg <= LEN_WIDTH'(1));

    always_comb begin
        in_body_next  = in_body_reg;
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        first_cr_next = first_cr_reg;
        value_next    = value_reg;
        seen_next     = seen_reg;
        remain_next   = remain_reg;
        parse_now     = 1'b0;
        res_valid     = 1'b0;
        res           = '0;

        if (in_body_reg) begin
            res_valid = 1'b1;
            res.kind  = KIND_BODY;
            res.data  = in_byte;
            res.last  = body_last;
            if (body_last) begin
                remain_next   = '0;
                in_body_next  = 1'b0;
                phase_next    = PH_PREFIX;
                pos_next      = '0;
                cnt_next      = '0;
                first_cr_next = 1'b0;
                value_next    = '0;
                seen_next     = 1'b0;
            end else begin
                remain_next = remain_reg - LEN_WIDTH'(1);
            end
        end else if (in_byte == CH_LF) begin
            phase_next    = PH_PREFIX;
            pos_next      = '0;
            cnt_next      = '0;
            first_cr_next = 1'b0;
            if (line_ends) begin
                value_next = '0;
                seen_next  = 1'b0;
                if (!seen_reg || value_reg == '0) begin
                    res_valid = 1'b1;
                    res.kind  = KIND_SKIP;
                end else begin
                    remain_next  = value_reg;
                    in_body_next = 1'b1;
                end
            end
        end else begin
            if (cnt_reg == '0 && in_byte == CH_CR) begin
                first_cr_next = 1'b1;
            end
            if (cnt_reg != CNT_MAX) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            unique case (phase_reg)
                PH_PREFIX: begin
                    if (pos_reg != POS_W'(PREFIX_LEN)) begin
                        if (lc == prefix_char(pos_reg)) begin
                            pos_next = pos_reg + POS_W'(1);
                        end else begin
                            phase_next = PH_IGNORE;
                        end
                    end else begin
                        seen_next = 1'b1;
                        parse_now = 1'b1;
                    end
                end
                PH_BLANK: begin
                    parse_now = 1'b1;
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        value_next = acc_sat;
                    end else begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_IGNORE: begin
                end
                default: begin
                    phase_next = PH_IGNORE;
                end
            endcase
            if (parse_now) begin
                value_next = acc_base;
                if (is_blank) begin
                    phase_next = PH_BLANK;
                end else if (is_digit) begin
                    phase_next = PH_DIGITS;
                    value_next = acc_sat;
                end else begin
                    phase_next = PH_IGNORE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_body_reg  <= 1'b0;
            phase_reg    <= PH_PREFIX;
            pos_reg      <= '0;
            cnt_reg      <= '0;
            first_cr_reg <= 1'b0;
            value_reg    <= '0;
            seen_reg     <= 1'b0;
            remain_reg   <= '0;
        end else if (en) begin
            in_body_reg  <= in_body_next;
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            first_cr_reg <= first_cr_next;
            value_reg    <= value_next;
            seen_reg     <= seen_next;
            remain_reg   <= remain_next;
        end
    end

endmodule

FILE: sv/cld_out_reg.sv
// Result register that holds a finished result until the receiver takes it.
module cld_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  cld_pkg::result_t in_res,
    output logic             can_load,
    output logic             out_valid,
    output cld_pkg::result_t out_res,
    input  logic             out_ready
);
    import cld_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && in_valid) begin
            res_reg <= in_res;
        end
    end

endmodule

FILE: sv/content_length_deframer.sv
// Top level of the content-length deframer: stream ports, parser and result register.
//
// Usage: bytes of a header-framed stream enter on the s_ channel, one per request.
// Header lines are parsed for a case-insensitive "Content-Length:" value; an empty
// or lone-CR line ends the header. With a nonzero length, that many following bytes
// leave on the m_ channel as body bytes (m_tuser = 0), the final one with m_tlast
// set. A header without a usable length yields one skip event (m_tuser = 1,
// m_tdata = 0, m_tlast = 0). Header bytes produce no result.
// Each result is registered and appears on m_ in the cycle after its byte is accepted.
// Throughput: one byte per cycle; s_tready is high whenever the result register
// is empty or is being emptied in the same cycle.
// Reset: aresetn low for one clock edge returns to the header phase with no
// length pending and drops any held result.
// Stall: while m_tready is low and a result is held, s_tready is low and the held
// result stays on m_ unchanged.
module content_length_deframer #(
    parameter int LEN_WIDTH = cld_pkg::LEN_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [cld_pkg::BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [cld_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic [0:0]                 m_tuser,   // [0] out_kind
    output logic                       m_tlast
);
    import cld_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign accept = s_tvalid && s_tready;

    cld_parser #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (accept),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    cld_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept && res_valid),
        .in_res    (res),
        .can_load  (s_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata    = out_res.data;
    assign m_tuser[0] = out_res.kind;
    assign m_tlast    = out_res.last;

endmodule

FILE: sv/cld_checker.sv
// Port-level checker for the deframer and its bind to the top level.
module cld_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);
    import cld_pkg::*;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

    a_skip_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == KIND_SKIP |-> m_tdata == 8'h00 && !m_tlast)
        else $error("skip event carries data or last");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(s_tvalid && s_tready) && !$past(m_tvalid && !m_tready)
        |-> !m_tvalid)
        else $error("result without accepted request");

endmodule

bind content_length_deframer cld_checker u_cld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
